[src/sffr_pkg.sv]
`default_nettype none

package sffr_pkg;

   localparam int FRAMES_DEFAULT = 1024;

   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 10;
   localparam int FRAME_W  = 2 * SAMPLE_W;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_DROP  = 2'd2;
   localparam logic [1:0] OP_RESET = 2'd3;

   typedef struct packed {
      logic [1:0]                 operation;
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
      logic [COUNT_W-1:0]         drop_count;
   } req_type;

   typedef struct packed {
      logic                       ok;
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic [COUNT_W-1:0]         dropped;
      logic [COUNT_W-1:0]         used_count;
      logic [COUNT_W-1:0]         free_count;
   } rsp_type;

endpackage

`default_nettype wire

[src/sffr_frame_mem.sv]
`default_nettype none

module sffr_frame_mem #(
   parameter int FRAMES = sffr_pkg::FRAMES_DEFAULT,
   parameter int PTR_W  = $clog2(FRAMES)
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [PTR_W-1:0]             wr_addr,
   input  wire logic [sffr_pkg::FRAME_W-1:0] wr_data,
   input  wire logic                         rd_en,
   input  wire logic [PTR_W-1:0]             rd_addr,
   output logic      [sffr_pkg::FRAME_W-1:0] rd_data
);

   logic [sffr_pkg::FRAME_W-1:0] frame_store [FRAMES];
   logic [sffr_pkg::FRAME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_store[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/sffr_ctrl.sv]
`default_nettype none

module sffr_ctrl #(
   parameter int FRAMES = sffr_pkg::FRAMES_DEFAULT,
   parameter int PTR_W  = $clog2(FRAMES)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire sffr_pkg::req_type            req_payload,
   output logic                              mem_wr_en,
   output logic      [PTR_W-1:0]             mem_wr_addr,
   output logic      [sffr_pkg::FRAME_W-1:0] mem_wr_data,
   output logic                              mem_rd_en,
   output logic      [PTR_W-1:0]             mem_rd_addr,
   input  wire logic [sffr_pkg::FRAME_W-1:0] mem_rd_data,
   output logic                              rsp_valid,
   output sffr_pkg::rsp_type                 rsp_payload
);

   localparam int CNT_W  = PTR_W + 1;
   localparam int WIDE_W = (PTR_W > sffr_pkg::COUNT_W) ? PTR_W : sffr_pkg::COUNT_W;
   localparam logic [PTR_W-1:0] LAST  = PTR_W'(FRAMES - 1);
   localparam logic [CNT_W-1:0] RANGE = CNT_W'(FRAMES);

   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in, used_ff, used_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             ok_ff, ok_in, pop_ok_ff, pop_ok_in;
   logic [sffr_pkg::COUNT_W-1:0] dropped_ff, dropped_in;
   logic [PTR_W-1:0] used_out_ff, free_out_ff, free_in;

   logic             full, empty;
   logic [PTR_W-1:0] wp_inc, rp_inc, n_ptr, wp_drop;
   logic [WIDE_W-1:0] req_wide, held_wide, n_wide, used_wide, free_wide;
   logic [CNT_W-1:0] back_diff, back_wrap;

   assign full   = (used_ff == LAST);
   assign empty  = (used_ff == '0);
   assign wp_inc = (wp_ff == LAST) ? '0 : wp_ff + PTR_W'(1);
   assign rp_inc = (rp_ff == LAST) ? '0 : rp_ff + PTR_W'(1);

   // The withdrawal is clamped to the frames held, so it always fits a pointer.
   assign req_wide  = WIDE_W'(req_payload.drop_count);
   assign held_wide = WIDE_W'(used_ff);
   assign n_wide    = (req_wide > held_wide) ? held_wide : req_wide;
   assign n_ptr     = n_wide[PTR_W-1:0];

   assign back_diff = {1'b0, wp_ff} - {1'b0, n_ptr};
   assign back_wrap = back_diff + RANGE;
   assign wp_drop   = back_diff[PTR_W] ? back_wrap[PTR_W-1:0] : back_diff[PTR_W-1:0];

   always_comb begin
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      used_in    = used_ff;
      ok_in      = 1'b0;
      pop_ok_in  = 1'b0;
      dropped_in = '0;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      if (accept) begin
         unique case (req_payload.operation)
            sffr_pkg::OP_PUSH: begin
               if (!full) begin
                  mem_wr_en = 1'b1;
                  wp_in     = wp_inc;
                  used_in   = used_ff + PTR_W'(1);
                  ok_in     = 1'b1;
               end
            end
            sffr_pkg::OP_POP: begin
               if (!empty) begin
                  mem_rd_en = 1'b1;
                  rp_in     = rp_inc;
                  used_in   = used_ff - PTR_W'(1);
                  ok_in     = 1'b1;
                  pop_ok_in = 1'b1;
               end
            end
            sffr_pkg::OP_DROP: begin
               if (n_ptr != '0) begin
                  wp_in      = wp_drop;
                  used_in    = used_ff - n_ptr;
                  ok_in      = 1'b1;
                  dropped_in = n_wide[sffr_pkg::COUNT_W-1:0];
               end
            end
            sffr_pkg::OP_RESET: begin
               wp_in   = '0;
               rp_in   = '0;
               used_in = '0;
               ok_in   = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid_in = accept;
   assign free_in      = LAST - used_in;
   assign mem_wr_addr  = wp_ff;
   assign mem_wr_data  = {req_payload.left_in, req_payload.right_in};
   assign mem_rd_addr  = rp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff       <= ok_in;
      pop_ok_ff   <= pop_ok_in;
      dropped_ff  <= dropped_in;
      used_out_ff <= used_in;
      free_out_ff <= free_in;
   end

   // Counts are reported in ten bits whatever the depth.
   assign used_wide = WIDE_W'(used_out_ff);
   assign free_wide = WIDE_W'(free_out_ff);

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_payload.ok         = ok_ff;
   assign rsp_payload.left_out   = pop_ok_ff ?
      mem_rd_data[sffr_pkg::FRAME_W-1:sffr_pkg::SAMPLE_W] : '0;
   assign rsp_payload.right_out  = pop_ok_ff ? mem_rd_data[sffr_pkg::SAMPLE_W-1:0] : '0;
   assign rsp_payload.dropped    = dropped_ff;
   assign rsp_payload.used_count = used_wide[sffr_pkg::COUNT_W-1:0];
   assign rsp_payload.free_count = free_wide[sffr_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire

[src/stereo_frame_fifo_with_rewind_core.sv]
// Latency: the result of an operation is strobed on rsp_valid in the cycle after it is taken.
// Throughput: one operation per cycle; busy stays low, as the frame store has a
// separate write and read port and a pop's read is issued at the accepting edge.
// The receiver cannot stall, so every result is shown for exactly one cycle.
// Reset empties the FIFO (pointers and count to zero); the frame store is not cleared.
`default_nettype none

module stereo_frame_fifo_with_rewind_core #(
   parameter int FRAMES = sffr_pkg::FRAMES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire sffr_pkg::req_type  req_payload,
   output logic                    rsp_valid,
   output sffr_pkg::rsp_type       rsp_payload
);

   localparam int PTR_W = $clog2(FRAMES);

   logic                         accept;
   logic                         mem_wr_en, mem_rd_en;
   logic [PTR_W-1:0]             mem_wr_addr, mem_rd_addr;
   logic [sffr_pkg::FRAME_W-1:0] mem_wr_data, mem_rd_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   sffr_ctrl #(
      .FRAMES (FRAMES),
      .PTR_W  (PTR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   sffr_frame_mem #(
      .FRAMES (FRAMES),
      .PTR_W  (PTR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

[src/sffr_checker.sv]
`default_nettype none

module sffr_checker #(
   parameter int FRAMES = sffr_pkg::FRAMES_DEFAULT
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire sffr_pkg::req_type req_payload,
   input wire logic              rsp_valid,
   input wire sffr_pkg::rsp_type rsp_payload
);

   localparam logic [sffr_pkg::COUNT_W-1:0] LAST_MASKED = sffr_pkg::COUNT_W'(FRAMES - 1);

   logic [sffr_pkg::COUNT_W-1:0] count_sum;

   assign count_sum = rsp_payload.used_count + rsp_payload.free_count;

   // Every accepted transfer yields exactly one result on the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("no result after an accepted transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result without an accepted transfer");

   a_counts_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_sum == LAST_MASKED))
      else $error("used and free counts do not add up to the capacity");

   a_failed_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.ok) |->
         (rsp_payload.left_out == '0 && rsp_payload.right_out == '0 &&
          rsp_payload.dropped == '0))
      else $error("failed operation carries data");

   a_reset_op_empties: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.operation == sffr_pkg::OP_RESET) |=>
         (rsp_payload.ok && rsp_payload.used_count == '0))
      else $error("reset operation did not empty the FIFO");

endmodule

bind stereo_frame_fifo_with_rewind_core sffr_checker #(
   .FRAMES (FRAMES)
) u_sffr_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int FULL_LEVEL = sffr_pkg::FRAMES_DEFAULT - 1;

   // Keeps its own copy of the ring and the expected results of transfers still in flight.
   class stereo_fifo_scoreboard;
      logic [sffr_pkg::FRAME_W-1:0] frame_copy [sffr_pkg::FRAMES_DEFAULT];
      logic [sffr_pkg::COUNT_W-1:0] wr_ptr;
      logic [sffr_pkg::COUNT_W-1:0] rd_ptr;
      sffr_pkg::rsp_type            pending_results [$];
      int mismatches;
      int accepted_ops;
      int checked;
      int full_rejects;
      int empty_pops;
      int clamped_drops;
      int clears;

      function new();
         wr_ptr        = '0;
         rd_ptr        = '0;
         mismatches    = 0;
         accepted_ops  = 0;
         checked       = 0;
         full_rejects  = 0;
         empty_pops    = 0;
         clamped_drops = 0;
         clears        = 0;
      endfunction

      function logic [sffr_pkg::COUNT_W-1:0] held();
         return wr_ptr - rd_ptr;
      endfunction

      function void note_request(sffr_pkg::req_type item);
         sffr_pkg::rsp_type            want;
         logic [sffr_pkg::COUNT_W-1:0] level;
         logic [sffr_pkg::COUNT_W-1:0] withdrawn;
         want  = '0;
         level = held();
         accepted_ops++;
         case (item.operation)
            sffr_pkg::OP_PUSH: begin
               if (level != FULL_LEVEL) begin
                  frame_copy[wr_ptr] = {item.left_in, item.right_in};
                  wr_ptr  = wr_ptr + 1'b1;
                  want.ok = 1'b1;
               end else begin
                  full_rejects++;
               end
            end
            sffr_pkg::OP_POP: begin
               if (level != 0) begin
                  want.left_out  = frame_copy[rd_ptr][sffr_pkg::FRAME_W-1:sffr_pkg::SAMPLE_W];
                  want.right_out = frame_copy[rd_ptr][sffr_pkg::SAMPLE_W-1:0];
                  rd_ptr  = rd_ptr + 1'b1;
                  want.ok = 1'b1;
               end else begin
                  empty_pops++;
               end
            end
            sffr_pkg::OP_DROP: begin
               withdrawn = (item.drop_count > level) ? level : item.drop_count;
               if (item.drop_count > level) clamped_drops++;
               if (withdrawn != 0) begin
                  wr_ptr       = wr_ptr - withdrawn;
                  want.dropped = withdrawn;
                  want.ok      = 1'b1;
               end
            end
            default: begin
               wr_ptr  = '0;
               rd_ptr  = '0;
               want.ok = 1'b1;
               clears++;
            end
         endcase
         want.used_count = held();
         want.free_count = sffr_pkg::COUNT_W'(FULL_LEVEL) - held();
         pending_results.push_back(want);
      endfunction

      function void compare_field(string name, logic [sffr_pkg::SAMPLE_W-1:0] want,
                                  logic [sffr_pkg::SAMPLE_W-1:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(sffr_pkg::rsp_type got);
         sffr_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            $error("result transfer arrived with no operation outstanding");
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         compare_field("ok", want.ok, got.ok);
         compare_field("left_out", want.left_out, got.left_out);
         compare_field("right_out", want.right_out, got.right_out);
         compare_field("dropped", want.dropped, got.dropped);
         compare_field("used_count", want.used_count, got.used_count);
         compare_field("free_count", want.free_count, got.free_count);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   sffr_pkg::req_type req_payload;
   logic              rsp_valid;
   sffr_pkg::rsp_type rsp_payload;

   stereo_fifo_scoreboard board;
   bit idling_on;

   stereo_frame_fifo_with_rewind_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_payload);
   end

   // Mostly random samples, with the sign and magnitude extremes mixed in.
   function automatic logic [sffr_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(19))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return sffr_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_op(input logic [1:0] op,
                          input logic [sffr_pkg::SAMPLE_W-1:0] left,
                          input logic [sffr_pkg::SAMPLE_W-1:0] right,
                          input logic [sffr_pkg::COUNT_W-1:0] count);
      sffr_pkg::req_type item;
      // Each cycle is left idle with the same chance, so gaps of any length turn up.
      while (idling_on && $urandom_range(99) < 26) begin
         start       <= 1'b0;
         req_payload <= sffr_pkg::req_type'({$urandom, $urandom});
         @(posedge clock);
      end
      item.operation  = op;
      item.left_in    = left;
      item.right_in   = right;
      item.drop_count = count;
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      board.note_request(item);
   endtask

   initial begin
      int roll;
      int push_pct;
      int pop_pct;
      int drop_pct;
      int reach;
      logic [sffr_pkg::COUNT_W-1:0] count;

      board       = new();
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      idling_on   = 1'b0;
      repeat (3) @(posedge clock);
      reset     <= 1'b0;
      idling_on = 1'b1;

      // Empty FIFO: failed pop and drops of nothing; then pushes of extreme samples, drops, pops and resets.
      send_op(sffr_pkg::OP_POP, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_DROP, pick_sample(), pick_sample(), 10'd0);
      send_op(sffr_pkg::OP_DROP, pick_sample(), pick_sample(), 10'h3FF);
      send_op(sffr_pkg::OP_PUSH, 16'h7FFF, 16'h8000, sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_PUSH, 16'h8000, 16'h7FFF, sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_PUSH, 16'h0000, 16'h0000, 10'h3FF);
      send_op(sffr_pkg::OP_PUSH, 16'hFFFF, 16'hFFFF, 10'h000);
      send_op(sffr_pkg::OP_PUSH, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_DROP, pick_sample(), pick_sample(), 10'd0);
      send_op(sffr_pkg::OP_DROP, pick_sample(), pick_sample(), 10'd1);
      send_op(sffr_pkg::OP_POP, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_POP, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_DROP, pick_sample(), pick_sample(), 10'h3FF);
      send_op(sffr_pkg::OP_POP, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_PUSH, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_PUSH, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_RESET, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_POP, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_PUSH, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_POP, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_RESET, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));

      // Fill to the brim back to back, knock on the full FIFO, then drain part of it so
      // that the write pointer wraps once random traffic resumes.
      idling_on = 1'b0;
      while (board.held() != FULL_LEVEL)
         send_op(sffr_pkg::OP_PUSH, pick_sample(), pick_sample(),
                 sffr_pkg::COUNT_W'($urandom));
      repeat (3)
         send_op(sffr_pkg::OP_PUSH, pick_sample(), pick_sample(),
                 sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_DROP, pick_sample(), pick_sample(), 10'd1);
      send_op(sffr_pkg::OP_PUSH, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      send_op(sffr_pkg::OP_PUSH, pick_sample(), pick_sample(), sffr_pkg::COUNT_W'($urandom));
      repeat (200)
         send_op(sffr_pkg::OP_POP, pick_sample(), pick_sample(),
                 sffr_pkg::COUNT_W'($urandom));
      idling_on = 1'b1;

      for (int i = 0; i < 650; i++) begin
         idling_on = !(i >= 300 && i < 380);
         case ((i / 80) % 4)
            0:       begin push_pct = 45; pop_pct = 35; drop_pct = 18; end
            1:       begin push_pct = 75; pop_pct = 13; drop_pct = 10; end
            2:       begin push_pct = 15; pop_pct = 73; drop_pct = 10; end
            default: begin push_pct = 35; pop_pct = 25; drop_pct = 38; end
         endcase
         roll = $urandom_range(99);
         if ($urandom_range(99) < 60) begin
            count = sffr_pkg::COUNT_W'($urandom_range(0, 6));
         end else if ($urandom_range(99) < 75) begin
            reach = board.held() + 2;
            count = sffr_pkg::COUNT_W'((reach > FULL_LEVEL) ? FULL_LEVEL :
                                       $urandom_range(0, reach));
         end else begin
            count = sffr_pkg::COUNT_W'($urandom);
         end
         if (roll < push_pct)
            send_op(sffr_pkg::OP_PUSH, pick_sample(), pick_sample(),
                    sffr_pkg::COUNT_W'($urandom));
         else if (roll < push_pct + pop_pct)
            send_op(sffr_pkg::OP_POP, pick_sample(), pick_sample(),
                    sffr_pkg::COUNT_W'($urandom));
         else if (roll < push_pct + pop_pct + drop_pct)
            send_op(sffr_pkg::OP_DROP, pick_sample(), pick_sample(), count);
         else
            send_op(sffr_pkg::OP_RESET, pick_sample(), pick_sample(),
                    sffr_pkg::COUNT_W'($urandom));
      end
      start <= 1'b0;

      for (int w = 0; w < 200 && board.pending_results.size() != 0; w++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (board.pending_results.size() != 0) begin
         $error("%0d expected results never arrived", board.pending_results.size());
         board.mismatches++;
      end

      $display("Ran %0d operations through the ring and checked %0d results.",
               board.accepted_ops, board.checked);
      $display("Seen: %0d pushes refused when full, %0d pops when empty, %0d clamped drops, %s",
               board.full_rejects, board.empty_pops, board.clamped_drops,
               $sformatf("%0d clears.", board.clears));
      if (board.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[files.f]
src/sffr_pkg.sv
src/sffr_frame_mem.sv
src/sffr_ctrl.sv
src/stereo_frame_fifo_with_rewind_core.sv
src/sffr_checker.sv
bench/testbench.sv
